// ===== rtl/splp_pkg.sv =====
// ----------------------------------------------------------------------------
// splp_pkg
// Shared constants and types for the strip page layout planner.
// ----------------------------------------------------------------------------
package splp_pkg;

  localparam int unsigned PIX_W   = 12;  // pixel counts and row numbers
  localparam int unsigned PCT_W   = 7;   // overlap percent
  localparam int unsigned IDX_W   = 4;   // strip index
  localparam int unsigned SUM_W   = 17;  // assembled height, running offset
  localparam int unsigned NUM_W   = 29;  // dividend of every divide
  localparam int unsigned PROD_W  = 19;  // strip width times percent
  localparam int unsigned CADDR_W = 2;   // register index

  // floor(x / 100) = (x * RECIP_100) >> RECIP_SH, exact for x below 2**19
  localparam int unsigned RECIP_W  = 20;
  localparam logic [RECIP_W-1:0] RECIP_100 = 20'd671089;
  localparam int unsigned RECIP_SH = 26;

  localparam logic [CADDR_W-1:0] REG_PANEL_WIDTH  = 2'd0;
  localparam logic [CADDR_W-1:0] REG_PANEL_HEIGHT = 2'd1;
  localparam logic [CADDR_W-1:0] REG_OVERLAP_PCT  = 2'd2;

  localparam logic [PIX_W-1:0] RST_PANEL_WIDTH  = 12'd480;
  localparam logic [PIX_W-1:0] RST_PANEL_HEIGHT = 12'd800;
  localparam logic [PCT_W-1:0] RST_OVERLAP_PCT  = 7'd10;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [SUM_W-1:0] sum_t;

endpackage

// ===== rtl/splp_in_if.sv =====
// ----------------------------------------------------------------------------
// splp_in_if
// Strip size channel.
// ----------------------------------------------------------------------------
interface splp_in_if;
  logic              valid;
  logic              ready;
  splp_pkg::pix_t    strip_width;
  splp_pkg::pix_t    strip_height;

  modport source (output valid, output strip_width, output strip_height, input ready);
  modport sink   (input valid, input strip_width, input strip_height, output ready);
endinterface

// ===== rtl/splp_out_if.sv =====
// ----------------------------------------------------------------------------
// splp_out_if
// Strip placement channel.
// ----------------------------------------------------------------------------
interface splp_out_if;
  logic                            valid;
  logic                            ready;
  logic [splp_pkg::IDX_W-1:0]      strip_index;
  splp_pkg::pix_t                  src_start;
  splp_pkg::pix_t                  src_count;
  splp_pkg::pix_t                  dst_start;
  splp_pkg::pix_t                  dst_count;
  splp_pkg::pix_t                  page_width;
  splp_pkg::pix_t                  page_height;
  splp_pkg::pix_t                  page_left;
  logic                            valid_res;
  logic                            last;

  modport source (output valid, output strip_index, output src_start, output src_count,
                  output dst_start, output dst_count, output page_width,
                  output page_height, output page_left, output valid_res, output last,
                  input ready);
  modport sink   (input valid, input strip_index, input src_start, input src_count,
                  input dst_start, input dst_count, input page_width,
                  input page_height, input page_left, input valid_res, input last,
                  output ready);
endinterface

// ===== rtl/splp_cfg_if.sv =====
// ----------------------------------------------------------------------------
// splp_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface splp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [splp_pkg::CADDR_W-1:0]      index;
  splp_pkg::pix_t                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/splp_div.sv =====
// ----------------------------------------------------------------------------
// splp_div
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// ----------------------------------------------------------------------------
module splp_div #(
  parameter int unsigned NW = 29,
  parameter int unsigned DW = 17,
  parameter int unsigned PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [PW-1:0] pay,
  output logic          out_v,
  output logic [NW-1:0] quo,
  output logic [PW-1:0] out_pay
);

  logic          v_r   [NW];
  logic [DW-1:0] rem_r [NW];
  logic [DW-1:0] den_r [NW];
  logic [NW-1:0] num_r [NW];
  logic [NW-1:0] quo_r [NW];
  logic [PW-1:0] pay_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic          v_i;
    logic [DW-1:0] rem_i, den_i;
    logic [NW-1:0] num_i, quo_i;
    logic [PW-1:0] pay_i;
    logic [DW:0]   sh_nxt, diff_nxt;
    logic          ge_nxt;

    if (k == 0) begin : g_first
      assign v_i   = in_v;
      assign rem_i = '0;
      assign den_i = den;
      assign num_i = num;
      assign quo_i = '0;
      assign pay_i = pay;
    end else begin : g_next
      assign v_i   = v_r[k-1];
      assign rem_i = rem_r[k-1];
      assign den_i = den_r[k-1];
      assign num_i = num_r[k-1];
      assign quo_i = quo_r[k-1];
      assign pay_i = pay_r[k-1];
    end

    assign sh_nxt   = {rem_i, num_i[NW-1]};
    assign diff_nxt = sh_nxt - {1'b0, den_i};
    assign ge_nxt   = (sh_nxt >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
      if (en) begin
        rem_r[k] <= ge_nxt ? diff_nxt[DW-1:0] : sh_nxt[DW-1:0];
        den_r[k] <= den_i;
        num_r[k] <= {num_i[NW-2:0], 1'b0};
        quo_r[k] <= {quo_i[NW-2:0], ge_nxt};
        pay_r[k] <= pay_i;
      end
    end
  end

  assign out_v   = v_r[NW-1];
  assign quo     = quo_r[NW-1];
  assign out_pay = pay_r[NW-1];

endmodule

// ===== rtl/strip_page_layout_planner.sv =====
// ----------------------------------------------------------------------------
// strip_page_layout_planner
// Page fit and per-strip placement for a page assembled from turned strips.
// Page fit runs through 5 + 29 + 1 register stages, then the placement path
// through 1 + 1 + 29 + 1 register stages to the first placement.
// Throughput: one placement per cycle while out_ch.ready holds; the placement
// sequencer gives STRIPS placements per item (one for a rejected item).
// Reset (rst_n low, synchronous): pipeline empty, registers to 480/800/10.
// ----------------------------------------------------------------------------
module strip_page_layout_planner #(
  parameter int unsigned STRIPS          = 4,
  parameter int unsigned MIN_OVERLAP_PCT = 0,
  parameter int unsigned MAX_OVERLAP_PCT = 50
) (
  input  logic        clk,
  input  logic        rst_n,
  splp_in_if.sink     in_ch,
  splp_out_if.source  out_ch,
  splp_cfg_if.sink    cfg_ch
);

  localparam int unsigned PIX_W = splp_pkg::PIX_W;
  localparam int unsigned SUM_W = splp_pkg::SUM_W;
  localparam int unsigned NUM_W = splp_pkg::NUM_W;
  localparam int unsigned IDX_W = splp_pkg::IDX_W;
  localparam int unsigned PCT_W = splp_pkg::PCT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STRIPS - 1);
  localparam logic [PCT_W-1:0] MIN_OV   = PCT_W'(MIN_OVERLAP_PCT);
  localparam logic [PCT_W-1:0] MAX_OV   = PCT_W'(MAX_OVERLAP_PCT);

  // ---------------- registers ----------------
  splp_pkg::pix_t     panel_w_r, panel_h_r;
  logic [PCT_W-1:0]   ov_pct_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_w_r <= splp_pkg::RST_PANEL_WIDTH;
      panel_h_r <= splp_pkg::RST_PANEL_HEIGHT;
      ov_pct_r  <= splp_pkg::RST_OVERLAP_PCT;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        splp_pkg::REG_PANEL_WIDTH:  panel_w_r <= cfg_ch.data;
        splp_pkg::REG_PANEL_HEIGHT: panel_h_r <= cfg_ch.data;
        splp_pkg::REG_OVERLAP_PCT:  ov_pct_r  <= cfg_ch.data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [PCT_W-1:0] ov_lo, ov_cl;
  assign ov_lo = (ov_pct_r < MIN_OV) ? MIN_OV : ov_pct_r;
  assign ov_cl = (ov_lo > MAX_OV) ? MAX_OV : ov_lo;

  // ---------------- stall control ----------------
  logic en, en_f, s_v_r, seq_v_r, seq_last, seq_free, seq_take;
  logic out_v_r;

  // the sequencer only loads on a cycle where S also moves on
  assign en       = !out_v_r || out_ch.ready;
  assign seq_free = en && (!seq_v_r || seq_last);
  assign seq_take = s_v_r && seq_free;
  assign en_f     = en && (!s_v_r || seq_free);
  assign in_ch.ready = en_f;

  // ---------------- A: capture ----------------
  logic a_v_r, a_rej_r;
  splp_pkg::pix_t a_along_r, a_across_r, a_pw_r, a_ph_r;
  logic [PCT_W-1:0] a_ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (en_f) a_v_r <= in_ch.valid;
    if (en_f) begin
      a_along_r  <= in_ch.strip_width;
      a_across_r <= in_ch.strip_height;
      a_pw_r     <= panel_w_r;
      a_ph_r     <= panel_h_r;
      a_ov_r     <= ov_cl;
      a_rej_r    <= (in_ch.strip_width == '0) || (in_ch.strip_height == '0) ||
                    (panel_w_r == '0) || (panel_h_r == '0);
    end
  end

  // ---------------- B: width times percent ----------------
  logic b_v_r, b_rej_r;
  splp_pkg::pix_t b_along_r, b_across_r, b_pw_r, b_ph_r;
  logic [splp_pkg::PROD_W-1:0] b_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (en_f) b_v_r <= a_v_r;
    if (en_f) begin
      b_prod_r   <= splp_pkg::PROD_W'(a_along_r) * splp_pkg::PROD_W'(a_ov_r);
      b_along_r  <= a_along_r;
      b_across_r <= a_across_r;
      b_pw_r     <= a_pw_r;
      b_ph_r     <= a_ph_r;
      b_rej_r    <= a_rej_r;
    end
  end

  // ---------------- C: divide by 100 via reciprocal ----------------
  localparam int unsigned QM_W = splp_pkg::PROD_W + splp_pkg::RECIP_W;
  logic c_v_r, c_rej_r;
  splp_pkg::pix_t c_along_r, c_across_r, c_pw_r, c_ph_r;
  logic [QM_W-1:0] c_qm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (en_f) c_v_r <= b_v_r;
    if (en_f) begin
      c_qm_r     <= QM_W'(b_prod_r) * QM_W'(splp_pkg::RECIP_100);
      c_along_r  <= b_along_r;
      c_across_r <= b_across_r;
      c_pw_r     <= b_pw_r;
      c_ph_r     <= b_ph_r;
      c_rej_r    <= b_rej_r;
    end
  end

  // ---------------- D: overlap rows, crop, assembled height ----------------
  splp_pkg::pix_t d_ovrows, d_crop;
  splp_pkg::sum_t d_asm;
  assign d_ovrows = c_qm_r[splp_pkg::RECIP_SH +: PIX_W];
  assign d_crop   = c_along_r - d_ovrows;
  assign d_asm    = SUM_W'(c_along_r) + SUM_W'(LAST_IDX) * SUM_W'(d_crop);

  logic d_v_r, d_rej_r;
  splp_pkg::pix_t d_along_r, d_across_r, d_pw_r, d_ph_r, d_ovrows_r, d_crop_r;
  splp_pkg::sum_t d_asm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else if (en_f) d_v_r <= c_v_r;
    if (en_f) begin
      d_along_r  <= c_along_r;
      d_across_r <= c_across_r;
      d_pw_r     <= c_pw_r;
      d_ph_r     <= c_ph_r;
      d_ovrows_r <= d_ovrows;
      d_crop_r   <= d_crop;
      d_asm_r    <= d_asm;
      d_rej_r    <= c_rej_r || (d_ovrows >= c_along_r);
    end
  end

  // ---------------- E: fit dividends ----------------
  logic e_v_r, e_rej_r;
  splp_pkg::pix_t e_along_r, e_across_r, e_pw_r, e_ph_r, e_ovrows_r, e_crop_r;
  splp_pkg::sum_t e_asm_r;
  logic [NUM_W-1:0] e_num1_r, e_num2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e_v_r <= 1'b0;
    else if (en_f) e_v_r <= d_v_r;
    if (en_f) begin
      e_num1_r   <= NUM_W'(d_asm_r) * NUM_W'(d_pw_r);
      e_num2_r   <= NUM_W'(d_across_r) * NUM_W'(d_ph_r);
      e_along_r  <= d_along_r;
      e_across_r <= d_across_r;
      e_pw_r     <= d_pw_r;
      e_ph_r     <= d_ph_r;
      e_ovrows_r <= d_ovrows_r;
      e_crop_r   <= d_crop_r;
      e_asm_r    <= d_asm_r;
      e_rej_r    <= d_rej_r;
    end
  end

  // ---------------- fit divides ----------------
  localparam int unsigned P1_W = 1 + 2 * PIX_W;
  localparam int unsigned P2_W = 3 * PIX_W + SUM_W;
  logic             q1_v, q2_v;
  logic [NUM_W-1:0] q1, q2;
  logic [P1_W-1:0]  q1_pay;
  logic [P2_W-1:0]  q2_pay;

  splp_div #(.NW(NUM_W), .DW(PIX_W), .PW(P1_W)) u_div_h (
    .clk(clk), .rst_n(rst_n), .en(en_f), .in_v(e_v_r),
    .num(e_num1_r), .den(e_across_r), .pay({e_rej_r, e_pw_r, e_ph_r}),
    .out_v(q1_v), .quo(q1), .out_pay(q1_pay)
  );

  splp_div #(.NW(NUM_W), .DW(SUM_W), .PW(P2_W)) u_div_w (
    .clk(clk), .rst_n(rst_n), .en(en_f), .in_v(e_v_r),
    .num(e_num2_r), .den(e_asm_r), .pay({e_along_r, e_crop_r, e_ovrows_r, e_asm_r}),
    .out_v(q2_v), .quo(q2), .out_pay(q2_pay)
  );

  logic           f_rej;
  splp_pkg::pix_t f_pw, f_ph, f_along, f_crop, f_ovrows, f_fitw, f_fith;
  splp_pkg::sum_t f_asm;
  logic           f_tall;
  assign {f_rej, f_pw, f_ph}               = q1_pay;
  assign {f_along, f_crop, f_ovrows, f_asm} = q2_pay;
  assign f_tall = (q1 > NUM_W'(f_ph));
  assign f_fith = f_tall ? f_ph : q1[PIX_W-1:0];
  assign f_fitw = f_tall ? q2[PIX_W-1:0] : f_pw;

  // ---------------- S: page fit result ----------------
  logic s_rej_r;
  splp_pkg::pix_t s_along_r, s_crop_r, s_ovrows_r, s_fitw_r, s_fith_r, s_left_r;
  splp_pkg::sum_t s_asm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s_v_r <= 1'b0;
    else if (en_f) s_v_r <= q1_v && q2_v;
    if (en_f) begin
      s_rej_r    <= f_rej || (f_fitw == '0) || (f_fith == '0);
      s_along_r  <= f_along;
      s_crop_r   <= f_crop;
      s_ovrows_r <= f_ovrows;
      s_asm_r    <= f_asm;
      s_fitw_r   <= f_fitw;
      s_fith_r   <= f_fith;
      s_left_r   <= (f_pw - f_fitw) >> 1;
    end
  end

  // ---------------- placement sequencer ----------------
  logic           seq_rej_r;
  logic [IDX_W-1:0] seq_idx_r;
  splp_pkg::pix_t seq_along_r, seq_crop_r, seq_ovrows_r, seq_fitw_r, seq_fith_r, seq_left_r;
  splp_pkg::sum_t seq_asm_r, seq_sofar_r, seq_sum_nxt;
  splp_pkg::pix_t seq_ss_nxt, seq_sc_nxt;

  assign seq_last    = seq_v_r && (seq_rej_r || (seq_idx_r == LAST_IDX));
  assign seq_ss_nxt  = (seq_idx_r == '0) ? '0 : seq_ovrows_r;
  assign seq_sc_nxt  = (seq_idx_r == '0) ? seq_along_r : seq_crop_r;
  assign seq_sum_nxt = seq_sofar_r + SUM_W'(seq_sc_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_v_r <= 1'b0;
    end else if (seq_take) begin
      seq_v_r <= 1'b1;
    end else if (en && seq_last) begin
      seq_v_r <= 1'b0;
    end
    if (seq_take) begin
      seq_idx_r    <= '0;
      seq_sofar_r  <= '0;
      seq_rej_r    <= s_rej_r;
      seq_along_r  <= s_along_r;
      seq_crop_r   <= s_crop_r;
      seq_ovrows_r <= s_ovrows_r;
      seq_asm_r    <= s_asm_r;
      seq_fitw_r   <= s_fitw_r;
      seq_fith_r   <= s_fith_r;
      seq_left_r   <= s_left_r;
    end else if (en && seq_v_r) begin
      seq_idx_r   <= seq_idx_r + 1'b1;
      seq_sofar_r <= seq_sum_nxt;
    end
  end

  // ---------------- M: seam dividend ----------------
  localparam int unsigned P3_W = 2 + IDX_W + 5 * PIX_W;
  logic m_v_r;
  logic [NUM_W-1:0] m_num_r;
  splp_pkg::sum_t   m_den_r;
  logic [P3_W-1:0]  m_pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m_v_r <= 1'b0;
    else if (en) m_v_r <= seq_v_r;
    if (en) begin
      m_num_r <= NUM_W'(seq_sum_nxt) * NUM_W'(seq_fith_r);
      m_den_r <= seq_asm_r;
      m_pay_r <= {seq_rej_r, seq_last, seq_idx_r, seq_ss_nxt, seq_sc_nxt,
                  seq_fitw_r, seq_fith_r, seq_left_r};
    end
  end

  logic             q3_v;
  logic [NUM_W-1:0] q3;
  logic [P3_W-1:0]  q3_pay;

  splp_div #(.NW(NUM_W), .DW(SUM_W), .PW(P3_W)) u_div_seam (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(m_v_r),
    .num(m_num_r), .den(m_den_r), .pay(m_pay_r),
    .out_v(q3_v), .quo(q3), .out_pay(q3_pay)
  );

  logic           g_rej, g_last;
  logic [IDX_W-1:0] g_idx;
  splp_pkg::pix_t g_ss, g_sc, g_fitw, g_fith, g_left, g_end;
  assign {g_rej, g_last, g_idx, g_ss, g_sc, g_fitw, g_fith, g_left} = q3_pay;
  assign g_end = q3[PIX_W-1:0];

  // ---------------- output register ----------------
  splp_pkg::pix_t prev_r;
  logic [IDX_W-1:0] o_idx_r;
  splp_pkg::pix_t o_ss_r, o_sc_r, o_ds_r, o_dc_r, o_pw_r, o_ph_r, o_pl_r;
  logic o_vres_r, o_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      prev_r  <= '0;
    end else if (en) begin
      out_v_r <= q3_v;
      if (q3_v) prev_r <= (g_last || g_rej) ? '0 : g_end;
    end
    if (en) begin
      o_idx_r  <= g_rej ? '0 : g_idx;
      o_ss_r   <= g_rej ? '0 : g_ss;
      o_sc_r   <= g_rej ? '0 : g_sc;
      o_ds_r   <= g_rej ? '0 : prev_r;
      o_dc_r   <= g_rej ? '0 : g_end - prev_r;
      o_pw_r   <= g_rej ? '0 : g_fitw;
      o_ph_r   <= g_rej ? '0 : g_fith;
      o_pl_r   <= g_rej ? '0 : g_left;
      o_vres_r <= !g_rej;
      o_last_r <= g_last;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.strip_index = o_idx_r;
  assign out_ch.src_start   = o_ss_r;
  assign out_ch.src_count   = o_sc_r;
  assign out_ch.dst_start   = o_ds_r;
  assign out_ch.dst_count   = o_dc_r;
  assign out_ch.page_width  = o_pw_r;
  assign out_ch.page_height = o_ph_r;
  assign out_ch.page_left   = o_pl_r;
  assign out_ch.valid_res   = o_vres_r;
  assign out_ch.last        = o_last_r;

  // ---------------- assertions ----------------
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !o_vres_r |-> o_last_r && o_idx_r == '0 && o_ph_r == '0 && o_pw_r == '0)
    else $error("rejected item carries nonzero fields");

  a_seam_in_page: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && o_vres_r |-> ({1'b0, o_ds_r} + {1'b0, o_dc_r}) <= {1'b0, o_ph_r})
    else $error("seam beyond fitted page height");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && o_vres_r |-> (o_last_r == (o_idx_r == LAST_IDX)))
    else $error("last flag out of step with strip index");

  a_seq_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    seq_v_r && !seq_last && !en |=> seq_v_r && $stable(seq_idx_r))
    else $error("sequencer moved while stalled");

endmodule

// ===== dv/strip_page_layout_planner_test.sv =====
// ----------------------------------------------------------------------------
// strip_page_layout_planner_test
// Drives strip sizes and register writes into the layout planner, predicts
// every strip placement in the testbench, and checks each result in order.
// ----------------------------------------------------------------------------
module strip_page_layout_planner_test;

  localparam int unsigned N_STRIPS = 4;
  localparam int unsigned MIN_PCT  = 0;
  localparam int unsigned MAX_PCT  = 50;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [splp_pkg::CADDR_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [splp_pkg::IDX_W-1:0] strip_index;
    splp_pkg::pix_t src_start;
    splp_pkg::pix_t src_count;
    splp_pkg::pix_t dst_start;
    splp_pkg::pix_t dst_count;
    splp_pkg::pix_t page_width;
    splp_pkg::pix_t page_height;
    splp_pkg::pix_t page_left;
    logic valid_res;
    logic last;
  } placement_t;

  logic clk;
  logic rst_n;

  splp_in_if  in_ch();
  splp_out_if out_ch();
  splp_cfg_if cfg_ch();

  strip_page_layout_planner #(
    .STRIPS(N_STRIPS), .MIN_OVERLAP_PCT(MIN_PCT), .MAX_OVERLAP_PCT(MAX_PCT)
  ) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  splp_pkg::pix_t panel_w;
  splp_pkg::pix_t panel_h;
  logic [splp_pkg::PCT_W-1:0] overlap_pct;

  placement_t expected_placements[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned items_sent;
  int unsigned rejects_sent;
  int unsigned cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic placement_t rejected_placement();
    placement_t p;
    p = '0;
    p.last = 1'b1;
    return p;
  endfunction

  // Layout of one page; appends the placements it produces.
  function automatic void plan_page(splp_pkg::pix_t along, splp_pkg::pix_t across);
    longint unsigned ov, ovrows, crop, assembled, fitw, fith, left, sofar, prev, stop;
    placement_t p;
    if (along == 0 || across == 0 || panel_w == 0 || panel_h == 0) begin
      expected_placements.push_back(rejected_placement());
      return;
    end
    ov = overlap_pct;
    if (ov < MIN_PCT) ov = MIN_PCT;
    if (ov > MAX_PCT) ov = MAX_PCT;
    ovrows = along * ov / 100;
    if (ovrows >= along) begin
      expected_placements.push_back(rejected_placement());
      return;
    end
    crop = along - ovrows;
    assembled = along + (N_STRIPS - 1) * crop;
    fith = assembled * panel_w / across;
    if (fith <= panel_h) fitw = panel_w;
    else begin
      fith = panel_h;
      fitw = across * panel_h / assembled;
    end
    if (fitw == 0 || fith == 0) begin
      expected_placements.push_back(rejected_placement());
      return;
    end
    left = (panel_w - fitw) / 2;
    sofar = 0;
    prev = 0;
    for (int i = 0; i < N_STRIPS && i < 16; i++) begin
      p.strip_index = splp_pkg::IDX_W'(i);
      p.src_start   = (i == 0) ? '0 : splp_pkg::pix_t'(ovrows);
      p.src_count   = (i == 0) ? along : splp_pkg::pix_t'(crop);
      sofar += (i == 0) ? longint'(along) : crop;
      stop = sofar * fith / assembled;
      p.dst_start   = splp_pkg::pix_t'(prev);
      p.dst_count   = splp_pkg::pix_t'(stop - prev);
      p.page_width  = splp_pkg::pix_t'(fitw);
      p.page_height = splp_pkg::pix_t'(fith);
      p.page_left   = splp_pkg::pix_t'(left);
      p.valid_res   = 1'b1;
      p.last        = (i == N_STRIPS - 1 || i == 15);
      expected_placements.push_back(p);
      prev = stop;
    end
  endfunction

  // Result checker.
  always @(posedge clk) begin
    placement_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.strip_index, out_ch.src_start, out_ch.src_count, out_ch.dst_start,
              out_ch.dst_count, out_ch.page_width, out_ch.page_height, out_ch.page_left,
              out_ch.valid_res, out_ch.last};
      results_seen++;
      if (expected_placements.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected placement %p", got);
      end else begin
        want = expected_placements.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Leaves valid high after the accept; a later idle or drain() drops it.
  task automatic send_strip(splp_pkg::pix_t along, splp_pkg::pix_t across);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.strip_width  <= along;
    in_ch.strip_height <= across;
    plan_page(along, across);
    items_sent++;
    if (expected_placements.size() > 0 && expected_placements[$].valid_res == 1'b0)
      rejects_sent++;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_placements.size() > 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(logic [splp_pkg::CADDR_W-1:0] idx, splp_pkg::pix_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      splp_pkg::REG_PANEL_WIDTH:  panel_w = value;
      splp_pkg::REG_PANEL_HEIGHT: panel_h = value;
      splp_pkg::REG_OVERLAP_PCT:  overlap_pct = value[splp_pkg::PCT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_panel(splp_pkg::pix_t w, splp_pkg::pix_t h,
                           logic [splp_pkg::PCT_W-1:0] pct);
    drain();
    write_reg(splp_pkg::REG_PANEL_WIDTH, w);
    write_reg(splp_pkg::REG_PANEL_HEIGHT, h);
    write_reg(splp_pkg::REG_OVERLAP_PCT, splp_pkg::pix_t'(pct));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_strip(12'd600, 12'd1200);
    send_strip(12'd0, 12'd100);
    send_strip(12'd100, 12'd0);
    send_strip(12'hFFF, 12'hFFF);
    send_strip(12'd1, 12'd1);
    send_strip(12'd1, 12'hFFF);
    send_strip(12'hFFF, 12'd1);
    send_strip(12'hAAA, 12'h555);
    send_strip(12'h555, 12'hAAA);
    // overlap above the clamp limit, then none
    set_panel(12'hFFF, 12'hFFF, 7'd100);
    send_strip(12'd1, 12'd1);
    send_strip(12'hFFF, 12'hFFF);
    send_strip(12'd200, 12'd300);
    set_panel(12'd1, 12'd1, 7'd0);
    send_strip(12'hFFF, 12'hFFF);
    send_strip(12'd1, 12'hFFF);
    send_strip(12'd37, 12'd19);
    // zero panel size rejects
    set_panel(12'd0, 12'd800, 7'd10);
    send_strip(12'd100, 12'd100);
    set_panel(12'd480, 12'd0, 7'd10);
    send_strip(12'd100, 12'd100);
    // unused register index is ignored
    drain();
    write_reg(REG_UNUSED, 12'hFFF);
    cfg_ch.valid <= 1'b0;
    set_panel(12'd480, 12'd800, 7'd127);
    send_strip(12'd640, 12'd480);
  endtask

  task automatic test_random(int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        if ($urandom_range(3) == 0)
          set_panel(splp_pkg::pix_t'($urandom), splp_pkg::pix_t'($urandom), 7'($urandom));
        else
          set_panel(splp_pkg::pix_t'($urandom_range(4095, 1)),
                    splp_pkg::pix_t'($urandom_range(4095, 1)),
                    7'($urandom_range(100)));
      end
      case ($urandom_range(9))
        0: send_strip(splp_pkg::pix_t'($urandom_range(3)), splp_pkg::pix_t'($urandom));
        1: send_strip(splp_pkg::pix_t'($urandom), splp_pkg::pix_t'($urandom_range(3)));
        2: send_strip(splp_pkg::pix_t'($urandom_range(64, 1)),
                      splp_pkg::pix_t'($urandom_range(64, 1)));
        default: send_strip(splp_pkg::pix_t'($urandom), splp_pkg::pix_t'($urandom));
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cycles = 0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    rejects_sent = 0;
    send_idle_pct = 11;
    recv_stall_pct = 46;
    panel_w = splp_pkg::RST_PANEL_WIDTH;
    panel_h = splp_pkg::RST_PANEL_HEIGHT;
    overlap_pct = splp_pkg::RST_OVERLAP_PCT;
    in_ch.valid = 1'b0;
    in_ch.strip_width = '0;
    in_ch.strip_height = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(150);
    send_idle_pct = 46;
    recv_stall_pct = 11;
    test_random(150);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(140);
    drain();

    $display("sent %0d strip sizes (%0d rejected), checked %0d placements",
             items_sent, rejects_sent, results_seen);
    $display("covered several panel and overlap settings under varied idling");
    if (mismatches == 0 && expected_placements.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d placements missing", mismatches,
               expected_placements.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
